// ----- sv/srre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srre_pkg: shared types and constants of the serial request/response engine
// Command format, front queue word, result word and sizing constants.
// ----------------------------------------------------------------------------
package srre_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// front queue depth, a power of two so the pointers wrap by themselves
	localparam int FQ_DEPTH = 4;
	localparam int FQ_W     = $clog2(FQ_DEPTH);

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

	localparam logic [7:0] MEM_RAM_CODE    = 8'h80;
	localparam logic [7:0] MEM_EEPROM_CODE = 8'hA0;
	localparam logic [7:0] MEM_EEPROM_MAP  = 8'h20;
	localparam logic [7:0] MEM_RAM_MAP     = 8'h00;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_PAIR = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [2:0] TX_COUNT_TWO  = 3'd2;
	localparam logic [2:0] TX_COUNT_FOUR = 3'd4;

	typedef struct packed {
		logic       four;
		logic [7:0] b3;
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
	} cmd_t;

	typedef enum logic [1:0] {
		OP_ENQ,
		OP_PAIR,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       urgent;
		cmd_t       req;
		logic [7:0] rx_first;
		logic [7:0] rx_second;
	} item_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] tx_count;
		logic [7:0] tx_byte0;
		logic [7:0] tx_byte1;
		logic [7:0] tx_byte2;
		logic [7:0] tx_byte3;
		logic [7:0] reply_value;
		logic       reply_ok;
		logic [7:0] reply_memory;
		logic [7:0] reply_address;
		logic       flush_rx;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              sending;
	} stat_t;

endpackage

// ----- sv/srre_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srre_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/srre_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srre_front: input side of the engine
// Accepts input words, classifies the command code and queues them.
// ----------------------------------------------------------------------------
module srre_front import srre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic       urgent,
	input  logic       req_four,
	input  logic [7:0] req_byte0,
	input  logic [7:0] req_byte1,
	input  logic [7:0] req_byte2,
	input  logic [7:0] req_byte3,
	input  logic [7:0] rx_first,
	input  logic [7:0] rx_second,
	output logic       fq_valid,
	output item_t      fq_word,
	input  logic       fq_pop
);

	item_t           slots_q [FQ_DEPTH];
	logic [FQ_W-1:0] wr_ptr_q;
	logic [FQ_W-1:0] rd_ptr_q;
	logic [FQ_W:0]   count_q;
	item_t           item;
	logic            known;
	logic            push;

	always_comb begin
		item           = '0;
		known          = 1'b1;
		item.urgent    = urgent;
		item.req.four  = req_four;
		item.req.b0    = req_byte0;
		item.req.b1    = req_byte1;
		item.req.b2    = req_four ? req_byte2 : 8'd0;
		item.req.b3    = req_four ? req_byte3 : 8'd0;
		item.rx_first  = rx_first;
		item.rx_second = rx_second;
		case (cmd)
			CMD_ENQ:  item.op = OP_ENQ;
			CMD_PAIR: item.op = OP_PAIR;
			CMD_TICK: item.op = OP_TICK;
			default:  known   = 1'b0;
		endcase
	end

	assign in_stall = (count_q == (FQ_W + 1)'(FQ_DEPTH));
	// drop unused command codes
	assign push     = in_valid && !in_stall && known;
	assign fq_valid = (count_q != '0);
	assign fq_word  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fq_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !fq_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && fq_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ----- sv/srre_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srre_back: execution side of the engine
// Owns the pending command ring, the outstanding request and the result word.
// ----------------------------------------------------------------------------
module srre_back import srre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] timeout,
	input  logic        fq_valid,
	input  item_t       fq_word,
	output logic        fq_pop,
	input  logic        out_stall,
	output logic        out_valid,
	output res_t        out_word,
	output stat_t       stat
);

	typedef enum logic {
		ST_EXEC,
		ST_SEND
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SENT,
		PH_ECHO
	} phase_t;

	st_t               st_q;
	phase_t            phase_q;
	phase_t            phase_n;
	cmd_t              active_q;
	logic [QW-1:0]     head_q;
	logic [QW-1:0]     head_n;
	logic [QW-1:0]     head_dec;
	logic [QW-1:0]     head_adv;
	logic [QW-1:0]     tail;
	logic [QW:0]       tail_sum;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_n;
	logic [15:0]       wait_q;
	logic [15:0]       wait_n;
	logic [15:0]       wait_inc;
	logic              byp_q;
	cmd_t              byp_cmd_q;
	logic [QW-1:0]     send_slot_q;
	logic [QW-1:0]     rd_addr;
	logic              out_valid_q;
	res_t              out_q;
	res_t              res;
	res_t              tx_res;
	cmd_t              send_cmd;
	logic              has_res;
	logic              we;
	logic [QW-1:0]     slot;
	logic              send;
	logic              out_free;
	logic              go;
	logic              go_send;
	logic [7:0]        sum;
	logic              echo_head;
	logic              echo_tail;
	logic [$bits(cmd_t)-1:0] rdata;

	function automatic logic [7:0] map_memory(input logic [7:0] code);
		logic [7:0] m;
		m = code;
		if (code == MEM_RAM_CODE) begin
			m = MEM_RAM_MAP;
		end else if (code == MEM_EEPROM_CODE) begin
			m = MEM_EEPROM_MAP;
		end
		return m;
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign go       = (st_q == ST_EXEC) && fq_valid && out_free;
	assign go_send  = (st_q == ST_SEND) && out_free;
	assign fq_pop   = go;

	assign head_dec = (head_q == '0) ? QW'(QUEUE_DEPTH - 1) : head_q - 1'b1;
	assign tail_sum = (QW + 1)'(head_q) + (QW + 1)'(fill_q);
	assign tail     = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
		QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
	assign head_adv = (head_n == QW'(QUEUE_DEPTH - 1)) ? '0 : head_n + 1'b1;
	assign wait_inc = (wait_q == WAIT_MAX) ? wait_q : wait_q + 16'd1;

	assign sum       = active_q.b0 + active_q.b1 + fq_word.rx_second;
	assign echo_head = (fq_word.rx_first == active_q.b0) && (fq_word.rx_second == active_q.b1);
	assign echo_tail = (fq_word.rx_first == active_q.b2) && (fq_word.rx_second == active_q.b3);

	always_comb begin
		phase_n = phase_q;
		head_n  = head_q;
		fill_n  = fill_q;
		wait_n  = wait_q;
		has_res = 1'b0;
		res     = '0;
		we      = 1'b0;
		slot    = tail;
		case (fq_word.op)
			OP_ENQ: begin
				if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
					has_res  = 1'b1;
					res.kind = KIND_REJECT;
				end else begin
					we     = 1'b1;
					fill_n = fill_q + 1'b1;
					if (fq_word.urgent) begin
						head_n = head_dec;
						slot   = head_dec;
					end
				end
			end
			OP_PAIR: begin
				if (phase_q == PH_SENT && echo_head) begin
					phase_n = PH_ECHO;
				end else if (phase_q == PH_ECHO && active_q.four && echo_tail) begin
					phase_n = PH_ECHO;
				end else if (phase_q != PH_IDLE) begin
					has_res           = 1'b1;
					res.kind          = KIND_DONE;
					res.reply_value   = fq_word.rx_second;
					res.reply_ok      = (sum == fq_word.rx_first);
					res.reply_memory  = map_memory(active_q.b0);
					res.reply_address = active_q.b1;
					res.flush_rx      = (sum != fq_word.rx_first);
					phase_n           = PH_IDLE;
					wait_n            = '0;
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					wait_n = wait_inc;
					if (wait_inc >= timeout) begin
						has_res           = 1'b1;
						res.kind          = KIND_DONE;
						res.reply_memory  = map_memory(active_q.b0);
						res.reply_address = active_q.b1;
						res.flush_rx      = 1'b1;
						phase_n           = PH_IDLE;
						wait_n            = '0;
					end
				end
			end
			default: ;
		endcase
		send     = (phase_n == PH_IDLE) && (fill_n != '0);
		res.last = !send;
	end

	// take the word just written when it lands at the new head
	assign send_cmd = byp_q ? byp_cmd_q : cmd_t'(rdata);

	// hold the read on the sent slot while the transmit word waits
	assign rd_addr = (st_q == ST_SEND) ? send_slot_q : head_n;

	always_comb begin
		tx_res          = '0;
		tx_res.kind     = KIND_TX;
		tx_res.tx_count = send_cmd.four ? TX_COUNT_FOUR : TX_COUNT_TWO;
		tx_res.tx_byte0 = send_cmd.b0;
		tx_res.tx_byte1 = send_cmd.b1;
		tx_res.tx_byte2 = send_cmd.b2;
		tx_res.tx_byte3 = send_cmd.b3;
		tx_res.last     = 1'b1;
	end

	srre_ram #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (go && we),
		.waddr (slot),
		.wdata (fq_word.req),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_EXEC;
			phase_q     <= PH_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			wait_q      <= '0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				phase_q <= send ? PH_SENT : phase_n;
				head_q  <= send ? head_adv : head_n;
				fill_q  <= send ? fill_n - 1'b1 : fill_n;
				wait_q  <= send ? '0 : wait_n;
				byp_q   <= we && (slot == head_n);
				st_q    <= send ? ST_SEND : ST_EXEC;
			end else if (go_send) begin
				st_q <= ST_EXEC;
			end
			if ((go && has_res) || go_send) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byp_cmd_q   <= fq_word.req;
			send_slot_q <= head_n;
			if (has_res) begin
				out_q <= res;
			end
		end else if (go_send) begin
			active_q <= send_cmd;
			out_q    <= tx_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = out_q;
	assign stat.fill    = fill_q;
	assign stat.sending = (st_q == ST_SEND);

endmodule

// ----- sv/serial_request_response_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_request_response_engine_core: queued serial request/response engine
// Queues commands, sends one at a time and matches the answer or a timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per event: enqueue a
//   command, a received byte pair, or a millisecond tick. A four-deep input
//   queue absorbs words while the engine is busy; in_stall rises when full.
//   Output channel (out_valid/out_stall) carries result words: transmit,
//   request finished, or rejected. An event gives up to two words; the last
//   one has last set; a transmit word follows a finish or reject if last is 0.
//   Configuration channel (cfg_valid/cfg_ready) writes timeout_ticks; write
//   only while the engine is idle. cfg_ready is always high.
//   A word is registered in the input queue before the engine takes it.
//   The engine takes one event at a time and enters a send state when a
//   command is sent, since the command ring is a RAM with a registered read
//   port. A stalled output holds its word and the engine waits; input keeps
//   filling the input queue. Reset empties both queues, sets the engine idle
//   and timeout_ticks to 1000. The command ring needs no clearing pass.
// ----------------------------------------------------------------------------
module serial_request_response_engine_core import srre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        urgent,
	input  logic        req_four,
	input  logic [7:0]  req_byte0,
	input  logic [7:0]  req_byte1,
	input  logic [7:0]  req_byte2,
	input  logic [7:0]  req_byte3,
	input  logic [7:0]  rx_first,
	input  logic [7:0]  rx_second,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [2:0]  tx_count,
	output logic [7:0]  tx_byte0,
	output logic [7:0]  tx_byte1,
	output logic [7:0]  tx_byte2,
	output logic [7:0]  tx_byte3,
	output logic [7:0]  reply_value,
	output logic        reply_ok,
	output logic [7:0]  reply_memory,
	output logic [7:0]  reply_address,
	output logic        flush_rx,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        fq_valid;
	item_t       fq_word;
	logic        fq_pop;
	res_t        out_word;
	stat_t       stat;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	srre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.urgent    (urgent),
		.req_four  (req_four),
		.req_byte0 (req_byte0),
		.req_byte1 (req_byte1),
		.req_byte2 (req_byte2),
		.req_byte3 (req_byte3),
		.rx_first  (rx_first),
		.rx_second (rx_second),
		.fq_valid  (fq_valid),
		.fq_word   (fq_word),
		.fq_pop    (fq_pop)
	);

	srre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.timeout   (timeout_q),
		.fq_valid  (fq_valid),
		.fq_word   (fq_word),
		.fq_pop    (fq_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word),
		.stat      (stat)
	);

	assign kind          = out_word.kind;
	assign tx_count      = out_word.tx_count;
	assign tx_byte0      = out_word.tx_byte0;
	assign tx_byte1      = out_word.tx_byte1;
	assign tx_byte2      = out_word.tx_byte2;
	assign tx_byte3      = out_word.tx_byte3;
	assign reply_value   = out_word.reply_value;
	assign reply_ok      = out_word.reply_ok;
	assign reply_memory  = out_word.reply_memory;
	assign reply_address = out_word.reply_address;
	assign flush_rx      = out_word.flush_rx;
	assign last          = out_word.last;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(QUEUE_DEPTH))
		else $error("command ring overfilled");

	a_tx_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_TX) |-> last)
		else $error("transmit word not last");

	a_flush_rule: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flush_rx == ((kind == KIND_DONE) && !reply_ok)))
		else $error("flush_rx does not match a failed request");

	a_send_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sending |-> (stat.fill != FILL_W'(QUEUE_DEPTH)))
		else $error("command ring full while sending");

endmodule
